>>> rtl/core/skbt_pkg.sv
// Shared types and constants for the sorted key binding table.
// Holds the request/response transaction structs, status and entry-kind codes.
// No dependencies.
package skbt_pkg;

	localparam int unsigned CAPACITY_DEF    = 64;
	localparam int unsigned SUBMAP_BITS_DEF = 8;

	localparam int unsigned KEY_CODE_W = 16;
	localparam int unsigned KEY_MODS_W = 3;
	localparam int unsigned KEY_W      = KEY_CODE_W + KEY_MODS_W;
	localparam int unsigned CMD_W      = 16;
	localparam int unsigned SUBMAP_W   = 8;

	// Request kinds; the last code is unused and always rejected
	localparam logic [1:0] REQ_BIND_CMD    = 2'd0;
	localparam logic [1:0] REQ_BIND_SUBMAP = 2'd1;
	localparam logic [1:0] REQ_LOOKUP      = 2'd2;
	localparam logic [1:0] REQ_UNUSED      = 2'd3;

	// Entry kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_COMMAND = 2'd1;
	localparam logic [1:0] KIND_SUBMAP  = 2'd2;

	// Response status
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_INVALID   = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	// Command value carried by sub-table entries
	localparam logic signed [CMD_W-1:0] CMD_NONE = -16'sd1;

	typedef struct packed {
		logic [1:0]              kind;
		logic [KEY_CODE_W-1:0]   key_code;
		logic [KEY_MODS_W-1:0]   key_mods;
		logic signed [CMD_W-1:0] new_command;
		logic [SUBMAP_W-1:0]     submap_number;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [1:0]              bound_kind;
		logic signed [CMD_W-1:0] bound_command;
		logic [SUBMAP_W-1:0]     bound_submap;
	} rsp_t;

endpackage

>>> rtl/core/sorted_key_binding_table.sv
// Sorted key binding table: top level, control sequencer and entry memory.
// Depends on skbt_pkg for transaction types and codes.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------
//   req     | in        | req_valid / req_stall | skbt_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_stall | skbt_pkg::rsp_t
//
// One transaction at a time; req_stall stays high until its response is loaded.
// A rejected bind goes straight to respond. A search runs probes (read, compare),
// at most ceil(log2(count+1)) of them, then a step to finish a miss and one to respond.
// An insert moves the (count - slot) entries above the slot up, one entry per cycle
// through the single write port, then writes its entry. Reset clears only count
// and control. A stalled response holds while the next transaction is worked on.
module sorted_key_binding_table #(
	parameter int unsigned CAPACITY    = skbt_pkg::CAPACITY_DEF,
	parameter int unsigned SUBMAP_BITS = skbt_pkg::SUBMAP_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  skbt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output skbt_pkg::rsp_t  rsp
);
	import skbt_pkg::*;

	// Index width for the memory, count width that can also hold CAPACITY
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	// Stored sub-table bits: the field never carries more than SUBMAP_W bits
	localparam int unsigned SB = (SUBMAP_BITS < SUBMAP_W) ? SUBMAP_BITS : SUBMAP_W;
	localparam int unsigned EW = KEY_W + 2 + CMD_W + SB;

	// Entry layout, high to low: key, kind, command, sub-table
	localparam int unsigned CMD_LO  = SB;
	localparam int unsigned KIND_LO = SB + CMD_W;
	localparam int unsigned KEY_LO  = SB + CMD_W + 2;

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	// Entry memory: one write port, one registered read port
	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rdata;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;

	// Control registers
	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          pend_q, pend_d;
	logic          rsp_valid_q, rsp_valid_d;

	// Working registers
	req_t          req_q, req_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [AW-1:0] mid_q, mid_d;
	logic [CW-1:0] at_q, at_d;
	logic [CW-1:0] rd_ptr_q, rd_ptr_d;
	logic [AW-1:0] pend_addr_q, pend_addr_d;
	rsp_t          res_q, res_d;
	rsp_t          rsp_q;

	logic          rsp_load;
	logic          req_invalid;
	logic [KEY_W-1:0] in_key;
	logic [KEY_W-1:0] key_c;
	logic [SB-1:0] sub_c;
	logic [CW-1:0] mid_c;
	logic [EW-1:0] new_entry;
	rsp_t          new_rsp;
	rsp_t          rd_rsp;
	rsp_t          fail_rsp;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	// Reject bad binds and unused kinds straight from the request port
	assign in_key = {req.key_mods, req.key_code};
	assign req_invalid = (req.kind == REQ_UNUSED)
		|| ((req.kind != REQ_LOOKUP) && (in_key == '0))
		|| ((req.kind == REQ_BIND_SUBMAP) && (req.submap_number[SB-1:0] == '0));

	assign key_c = {req_q.key_mods, req_q.key_code};
	assign sub_c = req_q.submap_number[SB-1:0];
	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

	// Entry and response for the item's own binding
	always_comb begin
		if (req_q.kind == REQ_BIND_CMD) begin
			new_entry = {key_c, KIND_COMMAND, req_q.new_command, {SB{1'b0}}};
			new_rsp   = '{STAT_OK, KIND_COMMAND, req_q.new_command, '0};
		end else begin
			new_entry = {key_c, KIND_SUBMAP, CMD_NONE, sub_c};
			new_rsp   = '{STAT_OK, KIND_SUBMAP, CMD_NONE, SUBMAP_W'(sub_c)};
		end
	end

	assign rd_rsp = '{STAT_OK, rdata[KEY_LO-1:KIND_LO], rdata[KIND_LO-1:CMD_LO],
		SUBMAP_W'(rdata[SB-1:0])};
	assign fail_rsp = '{STAT_INVALID, KIND_NONE, '0, '0};

	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid_d = rsp_load || (rsp_valid_q && rsp_stall);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pend_d      = 1'b0;
		req_d       = req_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		mid_d       = mid_q;
		at_d        = at_q;
		rd_ptr_d    = rd_ptr_q;
		pend_addr_d = pend_addr_q;
		res_d       = res_q;
		raddr       = mid_c[AW-1:0];
		we          = 1'b0;
		waddr       = mid_q;
		wdata       = new_entry;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_d = req;
					lo_d  = '0;
					hi_d  = count_q;
					if (req_invalid) begin
						res_d   = fail_rsp;
						state_d = S_RESP;
					end else begin
						state_d = S_PROBE;
					end
				end
			end
			S_PROBE: begin
				if (lo_q < hi_q) begin
					// Issue the read of the midpoint entry
					mid_d   = mid_c[AW-1:0];
					state_d = S_CMP;
				end else if (req_q.kind == REQ_LOOKUP) begin
					res_d        = fail_rsp;
					res_d.status = STAT_NOT_FOUND;
					state_d      = S_RESP;
				end else if (count_q >= CW'(CAPACITY)) begin
					res_d        = fail_rsp;
					res_d.status = STAT_FULL;
					state_d      = S_RESP;
				end else begin
					// Open a slot at lo: move entries from the top down
					at_d     = lo_q;
					rd_ptr_d = count_q;
					state_d  = S_SHIFT;
				end
			end
			S_CMP: begin
				if (rdata[EW-1:KEY_LO] == key_c) begin
					if (req_q.kind == REQ_LOOKUP) begin
						res_d = rd_rsp;
					end else begin
						we    = 1'b1;
						res_d = new_rsp;
					end
					state_d = S_RESP;
				end else begin
					if (rdata[EW-1:KEY_LO] < key_c) begin
						lo_d = CW'(mid_q) + CW'(1);
					end else begin
						hi_d = CW'(mid_q);
					end
					state_d = S_PROBE;
				end
			end
			S_SHIFT: begin
				if (pend_q) begin
					// Write back the entry read last cycle, one slot up
					we    = 1'b1;
					waddr = pend_addr_q;
					wdata = rdata;
				end
				if (rd_ptr_q > at_q) begin
					raddr       = AW'(rd_ptr_q - CW'(1));
					pend_d      = 1'b1;
					pend_addr_d = AW'(rd_ptr_q);
					rd_ptr_d    = rd_ptr_q - CW'(1);
				end else if (!pend_q) begin
					we      = 1'b1;
					waddr   = AW'(at_q);
					wdata   = new_entry;
					count_d = count_q + CW'(1);
					res_d   = new_rsp;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			pend_q      <= pend_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q       <= req_d;
		lo_q        <= lo_d;
		hi_q        <= hi_d;
		mid_q       <= mid_d;
		at_q        <= at_d;
		rd_ptr_q    <= rd_ptr_d;
		pend_addr_q <= pend_addr_d;
		res_q       <= res_d;
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> bench/sorted_key_binding_table_test.sv
// Testbench for the sorted key binding table: drives bind and lookup transactions,
// predicts each response from a local sorted table and checks it field by field.
// Depends on skbt_pkg and the sorted_key_binding_table RTL.
`timescale 1ns / 1ps

module sorted_key_binding_table_test;
	import skbt_pkg::*;

	localparam int unsigned TABLE_DEPTH  = CAPACITY_DEF;
	localparam int unsigned SUBMAP_USED  = SUBMAP_BITS_DEF;
	localparam int unsigned SUBMAP_MASK  = (1 << SUBMAP_USED) - 1;
	localparam int unsigned KEY_MAX      = (1 << KEY_W) - 1;
	localparam int unsigned IDLE_PCT     = 23;
	localparam int unsigned POOL_SIZE    = 40;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned TAIL_CYCLES  = 200;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;

	// One entry of the predicted table, kept sorted by key like the block's memory
	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic [1:0]              kind;
		logic signed [CMD_W-1:0] command;
		logic [SUBMAP_W-1:0]     submap;
	} binding_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b1;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	binding_t         bindings [TABLE_DEPTH];
	int               binding_count = 0;
	rsp_t             expected_responses [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int unsigned      error_count = 0;
	int unsigned      cycle_count = 0;
	int unsigned      hold_cycles_left = 0;
	bit               sender_idles = 1'b1;
	bit               receiver_idles = 1'b1;

	sorted_key_binding_table #(
		.CAPACITY(TABLE_DEPTH),
		.SUBMAP_BITS(SUBMAP_USED)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort the run if the block stops making progress
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Apply one transaction to the predicted table and return the response it
	// should produce. Bisection over the sorted entries finds either the key or
	// the slot where a new key belongs.
	function automatic rsp_t apply_binding_request(input req_t item);
		logic [KEY_W-1:0]    key;
		logic [SUBMAP_W-1:0] sub;
		int                  lo;
		int                  hi;
		int                  mid;
		int                  slot;
		bit                  hit;
		rsp_t                result;
		key    = {item.key_mods, item.key_code};
		sub    = SUBMAP_W'(item.submap_number & SUBMAP_MASK);
		result = '0;
		lo     = 0;
		hi     = binding_count;
		mid    = 0;
		hit    = 1'b0;
		while (lo < hi && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (bindings[mid].key == key)
				hit = 1'b1;
			else if (bindings[mid].key < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		slot = hit ? mid : lo;

		if (item.kind == REQ_LOOKUP) begin
			if (hit && bindings[slot].kind != KIND_NONE) begin
				result.status        = STAT_OK;
				result.bound_kind    = bindings[slot].kind;
				result.bound_command = bindings[slot].command;
				result.bound_submap  = bindings[slot].submap;
			end else begin
				result.status = STAT_NOT_FOUND;
			end
			return result;
		end

		// Reject the unused kind, the zero key and a zero sub-table number
		if ((item.kind != REQ_BIND_CMD && item.kind != REQ_BIND_SUBMAP) || key == '0 ||
		    (item.kind == REQ_BIND_SUBMAP && sub == '0)) begin
			result.status = STAT_INVALID;
			return result;
		end

		if (!hit) begin
			if (binding_count >= TABLE_DEPTH) begin
				result.status = STAT_FULL;
				return result;
			end
			// Shift later entries up one slot to open the insert position
			for (int i = binding_count; i > slot; i--)
				bindings[i] = bindings[i - 1];
			binding_count++;
			bindings[slot].key = key;
		end

		if (item.kind == REQ_BIND_CMD) begin
			bindings[slot].kind    = KIND_COMMAND;
			bindings[slot].command = item.new_command;
			bindings[slot].submap  = '0;
		end else begin
			bindings[slot].kind    = KIND_SUBMAP;
			bindings[slot].command = CMD_NONE;
			bindings[slot].submap  = sub;
		end
		result.status        = STAT_OK;
		result.bound_kind    = bindings[slot].kind;
		result.bound_command = bindings[slot].command;
		result.bound_submap  = bindings[slot].submap;
		return result;
	endfunction

	function automatic req_t make_request(input logic [1:0] kind, input logic [KEY_W-1:0] key,
	                                      input logic [CMD_W-1:0] cmd,
	                                      input logic [SUBMAP_W-1:0] sub);
		req_t item;
		item.kind          = kind;
		item.key_code      = key[KEY_CODE_W-1:0];
		item.key_mods      = key[KEY_W-1:KEY_CODE_W];
		item.new_command   = cmd;
		item.submap_number = sub;
		return item;
	endfunction

	// Random command and a nonzero random sub-table number; unused fields still toggle
	function automatic req_t random_request(input logic [1:0] kind, input logic [KEY_W-1:0] key);
		return make_request(kind, key, CMD_W'($urandom), SUBMAP_W'($urandom_range(255, 1)));
	endfunction

	function automatic logic [1:0] random_bind_kind();
		return $urandom_range(1) ? REQ_BIND_SUBMAP : REQ_BIND_CMD;
	endfunction

	// Mostly well-formed traffic over a small key pool, so rebinds and lookup hits
	// are common; a few rejected binds and unused-kind requests mixed in
	function automatic req_t random_pool_request();
		logic [KEY_W-1:0] key;
		int unsigned      pick;
		req_t             item;
		key  = key_pool[$urandom_range(POOL_SIZE - 1)];
		pick = $urandom_range(99);
		if (pick < 40)
			item = random_request(REQ_BIND_CMD, key);
		else if (pick < 60)
			item = random_request(REQ_BIND_SUBMAP, key);
		else if (pick < 85)
			item = random_request(REQ_LOOKUP, key);
		else if (pick < 90)
			item = random_request(REQ_LOOKUP, KEY_W'($urandom_range(KEY_MAX)));
		else if (pick < 94)
			item = random_request(random_bind_kind(), '0);
		else if (pick < 97)
			item = make_request(REQ_BIND_SUBMAP, key, CMD_W'($urandom), '0);
		else
			item = random_request(REQ_UNUSED, key);
		return item;
	endfunction

	// Offer one transaction, with random idle cycles in front, and record its
	// expected response once the block takes it. Valid stays high afterwards so
	// back-to-back transactions need no extra assignment.
	task automatic send_request(input req_t item);
		while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected_responses.push_back(apply_binding_request(item));
	endtask

	// Drop valid and wait until every outstanding response has been checked
	task automatic drain_responses();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_responses.size() != 0);
	endtask

	// Receiver side: random stall, or a long hold-off when a test asks for one
	always @(posedge clk) begin
		if (hold_cycles_left > 0) begin
			hold_cycles_left = hold_cycles_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= receiver_idles && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Compare every accepted response with the oldest expectation
	always @(posedge clk) begin : check_responses
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_responses.size() == 0) begin
				report_mismatch($sformatf("unexpected response status %0d", rsp.status));
			end else begin
				want = expected_responses.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status got %0d expected %0d",
					                          rsp.status, want.status));
				if (rsp.bound_kind !== want.bound_kind)
					report_mismatch($sformatf("bound_kind got %0d expected %0d",
					                          rsp.bound_kind, want.bound_kind));
				if (rsp.bound_command !== want.bound_command)
					report_mismatch($sformatf("bound_command got %0d expected %0d",
					                          rsp.bound_command, want.bound_command));
				if (rsp.bound_submap !== want.bound_submap)
					report_mismatch($sformatf("bound_submap got %0d expected %0d",
					                          rsp.bound_submap, want.bound_submap));
			end
		end
	end

	// Empty table lookups, every STAT_INVALID case, extreme keys and commands, inserts at
	// front, middle and back, and overwrites that switch the entry kind
	task automatic test_directed();
		send_request(make_request(REQ_LOOKUP, '0, '0, '0));
		send_request(make_request(REQ_LOOKUP, 19'h12345, '0, '0));
		send_request(make_request(REQ_BIND_CMD, '0, 16'sd5, '0));
		send_request(make_request(REQ_BIND_SUBMAP, '0, '0, 8'd7));
		send_request(make_request(REQ_BIND_SUBMAP, 19'h00041, '0, '0));
		send_request(make_request(REQ_UNUSED, 19'h00041, 16'sd3, 8'd3));
		send_request(make_request(REQ_BIND_CMD, 19'h7FFFF, 16'sd32767, 8'hFF));
		send_request(make_request(REQ_BIND_CMD, 19'h00001, 16'sh8000, '0));
		send_request(make_request(REQ_BIND_SUBMAP, 19'h10000, 16'sd0, 8'd255));
		send_request(make_request(REQ_BIND_CMD, 19'h0FFFF, -16'sd1, 8'd9));
		send_request(make_request(REQ_BIND_SUBMAP, 19'h40061, 16'sd77, 8'd1));
		send_request(make_request(REQ_LOOKUP, 19'h00001, '0, '0));
		send_request(make_request(REQ_LOOKUP, 19'h7FFFF, -16'sd1, 8'hFF));
		send_request(make_request(REQ_LOOKUP, 19'h0FFFF, '0, '0));
		send_request(make_request(REQ_BIND_CMD, 19'h10000, 16'sd0, '0));
		send_request(make_request(REQ_BIND_SUBMAP, 19'h00001, 16'sd4, 8'd128));
		send_request(make_request(REQ_BIND_SUBMAP, 19'h0FFFF, 16'sd12, '0));
		send_request(make_request(REQ_LOOKUP, 19'h0FFFF, '0, '0));
		send_request(make_request(REQ_LOOKUP, 19'h10000, '0, '0));
		send_request(make_request(REQ_LOOKUP, 19'h00002, '0, '0));
		send_request(make_request(REQ_UNUSED, '0, '0, '0));
		send_request(make_request(REQ_LOOKUP, 19'h00001, '0, '0));
	endtask

	// Random traffic over a pool small enough that the table never fills
	task automatic test_random_pool(input int unsigned count);
		foreach (key_pool[i])
			key_pool[i] = KEY_W'($urandom_range(KEY_MAX, 1));
		repeat (count)
			send_request(random_pool_request());
	endtask

	// Both sides at full rate: no idle cycles, no stalls
	task automatic test_streaming(input int unsigned count);
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		repeat (count)
			send_request(random_pool_request());
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	// Hold the response side off for a long stretch so the block fills and
	// stalls its request side, then pause until every response is back
	task automatic test_backpressure(input int unsigned count);
		hold_cycles_left = HOLD_CYCLES;
		repeat (count)
			send_request(random_pool_request());
		drain_responses();
	endtask

	// Fill the table with new keys, hit the full case, then mix new keys,
	// rebinds, lookups and rejections on the full table
	task automatic test_fill_table(input int unsigned count);
		int unsigned      pick;
		logic [KEY_W-1:0] held_key;
		while (binding_count < TABLE_DEPTH)
			send_request(random_request(random_bind_kind(), KEY_W'($urandom_range(KEY_MAX, 1))));
		send_request(random_request(REQ_BIND_CMD, KEY_W'($urandom_range(KEY_MAX, 1))));
		send_request(random_request(REQ_BIND_SUBMAP, bindings[0].key));
		send_request(random_request(REQ_BIND_CMD, bindings[TABLE_DEPTH - 1].key));
		repeat (count) begin
			pick     = $urandom_range(99);
			held_key = bindings[$urandom_range(binding_count - 1)].key;
			if (pick < 45)
				send_request(random_request(random_bind_kind(),
				                            KEY_W'($urandom_range(KEY_MAX, 1))));
			else if (pick < 70)
				send_request(random_request(random_bind_kind(), held_key));
			else if (pick < 90)
				send_request(random_request(REQ_LOOKUP, held_key));
			else if (pick < 95)
				send_request(random_request(REQ_LOOKUP, KEY_W'($urandom_range(KEY_MAX))));
			else
				send_request(random_request(2'($urandom_range(3)),
				                            KEY_W'($urandom_range(1) ? 0 : $urandom)));
		end
	endtask

	initial begin
		// Assert reset at time zero, then release it at a clock edge
		arst_n <= 1'b0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_pool(700);
		test_streaming(200);
		test_backpressure(30);
		test_fill_table(850);

		// Let the last responses drain, then give the block time to show strays
		drain_responses();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (error_count == 0 && expected_responses.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/skbt_pkg.sv
rtl/core/sorted_key_binding_table.sv
bench/sorted_key_binding_table_test.sv
